[rtl/lvla_pkg.sv]
// ----------------------------------------------------------------------------
// lvla_pkg: shared types and constants of the low voltage latch annunciator
// Holds the register map, the word types that pass between stages and the
// helpers that reduce a millisecond stamp to its place in the flash period.
// ----------------------------------------------------------------------------
package lvla_pkg;

    // Register map of the configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_MV   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HOLD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_HOLD = 2'd3;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] RST_LOWER_MV   = 16'd6000;
    localparam logic [15:0] RST_UPPER_MV   = 16'd11000;
    localparam logic [31:0] RST_TRIG_HOLD  = 32'd10000;
    localparam logic [31:0] RST_CLEAR_HOLD = 32'd5000;

    // Flash pattern, all in milliseconds within one period.
    localparam logic [9:0] FLASH_PERIOD_MS  = 10'd1000;
    localparam logic [9:0] FLASH_ON1_END_MS = 10'd120;
    localparam logic [9:0] FLASH_ON2_BEG_MS = 10'd240;
    localparam logic [9:0] FLASH_ON2_END_MS = 10'd360;

    // Weights of the bytes and of bit 10 upwards, each taken modulo 1000.
    localparam logic [17:0] W_BYTE1 = 18'd256;
    localparam logic [17:0] W_BYTE2 = 18'd536;
    localparam logic [17:0] W_BYTE3 = 18'd216;
    localparam logic [12:0] W_K     = 13'd24;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_FORCE  = 1'b1;

    typedef struct packed {
        logic [15:0] lower_mv;
        logic [15:0] upper_mv;
        logic [31:0] trigger_hold_ms;
        logic [31:0] clear_hold_ms;
    } t_cfg;

    // Word held in the input stage: the fields plus the first fold of now_ms.
    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic        sensor_ok;
        logic [15:0] bus_mv;
        logic [17:0] now_fold;
    } t_item;

    typedef struct packed {
        logic alarm_active;
        logic light_override;
        logic light_level;
        logic restore_pulse;
    } t_result;

    // First fold: the stamp is congruent modulo 1000 to this weighted byte sum.
    function automatic logic [17:0] fold_bytes(input logic [31:0] t);
        logic [17:0] b0, b1, b2, b3;
        b0 = {10'd0, t[7:0]};
        b1 = {10'd0, t[15:8]};
        b2 = {10'd0, t[23:16]};
        b3 = {10'd0, t[31:24]};
        return b0 + b1 * W_BYTE1 + b2 * W_BYTE2 + b3 * W_BYTE3;
    endfunction

    // Finishes the reduction: two folds of 1024 = 24 (mod 1000), one subtract.
    function automatic logic [9:0] phase_of(input logic [17:0] s);
        logic [12:0] v1;
        logic [12:0] v2;
        logic [10:0] v3;
        v1 = {3'd0, s[9:0]} + {5'd0, s[17:10]} * W_K;
        v2 = {3'd0, v1[9:0]} + {10'd0, v1[12:10]} * W_K;
        v3 = v2[10:0];
        if (v3 >= {1'b0, FLASH_PERIOD_MS}) begin
            v3 = v3 - {1'b0, FLASH_PERIOD_MS};
        end
        return v3[9:0];
    endfunction

    function automatic logic pattern_lit(input logic [9:0] ph);
        return (ph < FLASH_ON1_END_MS) ||
               ((ph >= FLASH_ON2_BEG_MS) && (ph < FLASH_ON2_END_MS));
    endfunction

endpackage

[rtl/lvla_in_if.sv]
// ----------------------------------------------------------------------------
// lvla_in_if: input channel of the annunciator
// Carries one update or force-latch word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lvla_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] now_ms;
    logic        sensor_ok;
    logic [15:0] bus_mv;

    modport source (output valid, kind, now_ms, sensor_ok, bus_mv, input ready);
    modport sink   (input valid, kind, now_ms, sensor_ok, bus_mv, output ready);
endinterface

[rtl/lvla_out_if.sv]
// ----------------------------------------------------------------------------
// lvla_out_if: result channel of the annunciator
// Carries the alarm and light flags of one word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lvla_out_if;
    logic valid;
    logic ready;
    logic alarm_active;
    logic light_override;
    logic light_level;
    logic restore_pulse;

    modport source (output valid, alarm_active, light_override, light_level,
                    restore_pulse, input ready);
    modport sink   (input valid, alarm_active, light_override, light_level,
                    restore_pulse, output ready);
endinterface

[rtl/low_voltage_latch_annunciator.sv]
// ----------------------------------------------------------------------------
// low_voltage_latch_annunciator: latched low bus voltage alarm with flasher
// Channel   Dir  Handshake      Word
// i_in      in   valid/ready    kind, now_ms, sensor_ok, bus_mv
// o_out     out  valid/ready    alarm_active, light_override, light_level,
//                               restore_pulse
// i_cfg_*   in   write enable   register index, 32-bit data
//
// One word is taken per cycle unless a stalled result holds the input stage;
// each result passes the input stage, then the result register. The input
// stage folds now_ms modulo 1000 part way; the latch and timers update as the
// word leaves it. A stalled result holds both stages; the input stage still
// fills if empty. Synchronous active-low reset clears the latch, timers and
// valid flags and loads the default thresholds and hold times.
// ----------------------------------------------------------------------------
module low_voltage_latch_annunciator
    import lvla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lvla_in_if.sink               i_in,
    lvla_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_item   r_s1;
    logic    r_s1_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result core_result;
    logic    advance;
    logic    fire;
    logic    take;

    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_s1_valid && advance;
    assign i_in.ready = !r_s1_valid || advance;
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_mv        <= RST_LOWER_MV;
            r_cfg.upper_mv        <= RST_UPPER_MV;
            r_cfg.trigger_hold_ms <= RST_TRIG_HOLD;
            r_cfg.clear_hold_ms   <= RST_CLEAR_HOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOWER_MV:   r_cfg.lower_mv        <= i_cfg_data[15:0];
                CFG_UPPER_MV:   r_cfg.upper_mv        <= i_cfg_data[15:0];
                CFG_TRIG_HOLD:  r_cfg.trigger_hold_ms <= i_cfg_data;
                CFG_CLEAR_HOLD: r_cfg.clear_hold_ms   <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1.kind      <= i_in.kind;
            r_s1.now_ms    <= i_in.now_ms;
            r_s1.sensor_ok <= i_in.sensor_ok;
            r_s1.bus_mv    <= i_in.bus_mv;
            r_s1.now_fold  <= fold_bytes(i_in.now_ms);
        end
        if (fire) begin
            r_out <= core_result;
        end
    end

    lvla_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_s1),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    assign o_out.valid          = r_out_valid;
    assign o_out.alarm_active   = r_out.alarm_active;
    assign o_out.light_override = r_out.light_override;
    assign o_out.light_level    = r_out.light_level;
    assign o_out.restore_pulse  = r_out.restore_pulse;

`ifndef NO_ASSERTIONS
    // A restore pulse marks the word on which the latch fell, never a latched one.
    a_restore_unlatched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.restore_pulse |-> !o_out.alarm_active)
        else $error("restore pulse given while alarm latched");

    // The flasher only lights while it owns the light.
    a_level_needs_ovr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.light_level |-> o_out.light_override)
        else $error("light level set without override");

    // A word held in the input stage by a stalled result must not change.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !advance |=> r_s1_valid && $stable(r_s1))
        else $error("input stage word changed under stall");
`endif

endmodule

[rtl/lvla_core.sv]
// ----------------------------------------------------------------------------
// lvla_core: latch and hold timers of the annunciator
// Keeps the alarm latch and both start stamps, and works out the result of
// the word in the input stage; the state moves on when i_fire is high.
// ----------------------------------------------------------------------------
module lvla_core
    import lvla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic        r_latch,   n_latch;
    logic [31:0] r_win_st,  n_win_st;
    logic [31:0] r_rec_st,  n_rec_st;
    logic        r_prev,    n_prev;

    logic        in_window;
    logic        above;
    logic [31:0] win_eff;
    logic [31:0] rec_eff;
    logic [9:0]  phase;

    assign in_window = (i_item.bus_mv > i_cfg.lower_mv) && (i_item.bus_mv < i_cfg.upper_mv);
    assign above     = i_item.bus_mv > i_cfg.upper_mv;
    // A stamp of zero means the timer is idle, so it starts from this word.
    assign win_eff   = (r_win_st == 32'd0) ? i_item.now_ms : r_win_st;
    assign rec_eff   = (r_rec_st == 32'd0) ? i_item.now_ms : r_rec_st;
    assign phase     = phase_of(i_item.now_fold);

    always_comb begin
        n_latch  = r_latch;
        n_win_st = r_win_st;
        n_rec_st = r_rec_st;
        n_prev   = r_prev;
        o_result = '0;
        if (i_item.kind == KIND_FORCE) begin
            n_latch               = 1'b1;
            n_rec_st              = 32'd0;
            o_result.alarm_active = 1'b1;
        end else begin
            if (i_item.sensor_ok) begin
                if (!r_latch) begin
                    if (in_window) begin
                        n_win_st = win_eff;
                        if ((i_item.now_ms - win_eff) >= i_cfg.trigger_hold_ms) begin
                            n_latch  = 1'b1;
                            n_rec_st = 32'd0;
                        end
                    end else begin
                        n_win_st = 32'd0;
                    end
                end else begin
                    if (above) begin
                        n_rec_st = rec_eff;
                        if ((i_item.now_ms - rec_eff) >= i_cfg.clear_hold_ms) begin
                            n_latch  = 1'b0;
                            n_win_st = 32'd0;
                        end
                    end else begin
                        n_rec_st = 32'd0;
                    end
                end
            end
            o_result.alarm_active   = n_latch;
            o_result.light_override = n_latch;
            o_result.light_level    = n_latch && pattern_lit(phase);
            o_result.restore_pulse  = !n_latch && r_prev;
            n_prev                  = n_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch  <= 1'b0;
            r_win_st <= 32'd0;
            r_rec_st <= 32'd0;
            r_prev   <= 1'b0;
        end else if (i_fire) begin
            r_latch  <= n_latch;
            r_win_st <= n_win_st;
            r_rec_st <= n_rec_st;
            r_prev   <= n_prev;
        end
    end

endmodule
